// File: sv/tlbpt_pkg.sv
// ----------------------------------------------------------------------------
// tlbpt_pkg
// Shared types and constants for the TLB / page table translator.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

	// Default sizes
	localparam int TLB_DEPTH_DEF   = 16;
	localparam int PAGE_COUNT_DEF  = 256;
	localparam int FRAME_COUNT_DEF = 128;
	localparam int PAGE_BYTES_DEF  = 256;

	// Fixed port widths
	localparam int ADDR_W  = 16;
	localparam int PADDR_W = 15;
	localparam int EPAGE_W = 8;
	localparam int CFG_W   = 8;

	// Usable frame count after reset
	localparam logic [CFG_W-1:0] FRAMES_RESET = 8'd128;

	// Controller states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_OWNER,
		ST_CHECK,
		ST_FILL
	} tlbpt_state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic clear;
		logic accept;
		logic hit_done;
		logic map_done;
		logic fresh_done;
		logic evict_start;
		logic owner_rd;
		logic evict_check;
		logic fill_done;
	} tlbpt_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic clear_last;
		logic tlb_hit;
		logic map_valid;
		logic fresh_avail;
		logic out_free;
	} tlbpt_status_t;

endpackage

// File: sv/tlb_page_table_translator.sv
// ----------------------------------------------------------------------------
// tlb_page_table_translator
// Logical to physical address translation through a FIFO-refilled TLB and a
// page table, with demand paging and round-robin frame eviction.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------------
//  in       | in_valid / in_stall    | logical_address
//  out      | out_valid / out_stall  | physical_address, tlb_hit, page_loaded,
//           |                        | evict_valid, evicted_page
//  cfg      | cfg_wr_en              | cfg_wr_data (frames_in_use)
//
// TLB hit, resident page or fresh frame: accept, then TLB compare against
// the registered page map read.
// Eviction: frame owner read, then page map read of the old owner and its
// invalidation, then the page map write; these map steps share the single map port.
// After reset a clearing pass writes every page map entry (PAGE_COUNT of
// them, 256 by default), with in_stall high.
// A stalled output holds the finished transaction; the next one proceeds up
// to the cycle that produces its result.
// ----------------------------------------------------------------------------
module tlb_page_table_translator
	import tlbpt_pkg::*;
#(
	parameter int TLB_DEPTH   = TLB_DEPTH_DEF,
	parameter int PAGE_COUNT  = PAGE_COUNT_DEF,
	parameter int FRAME_COUNT = FRAME_COUNT_DEF,
	parameter int PAGE_BYTES  = PAGE_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [CFG_W-1:0]   cfg_wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [ADDR_W-1:0]  logical_address,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [PADDR_W-1:0] physical_address,
	output logic               tlb_hit,
	output logic               page_loaded,
	output logic               evict_valid,
	output logic [EPAGE_W-1:0] evicted_page
);

	tlbpt_cmd_t    cmd;
	tlbpt_status_t sts;

	// Sequencer
	tlbpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath
	tlbpt_dp #(
		.TLB_DEPTH   (TLB_DEPTH),
		.PAGE_COUNT  (PAGE_COUNT),
		.FRAME_COUNT (FRAME_COUNT),
		.PAGE_BYTES  (PAGE_BYTES)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data),
		.logical_address  (logical_address),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.physical_address (physical_address),
		.tlb_hit          (tlb_hit),
		.page_loaded      (page_loaded),
		.evict_valid      (evict_valid),
		.evicted_page     (evicted_page)
	);

endmodule

// File: sv/tlbpt_ctrl.sv
// ----------------------------------------------------------------------------
// tlbpt_ctrl
// Sequencer: page map clearing pass, lookup, and the eviction steps.
// ----------------------------------------------------------------------------
module tlbpt_ctrl
	import tlbpt_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  tlbpt_status_t sts,
	output tlbpt_cmd_t    cmd
);

	tlbpt_state_t state_q;
	tlbpt_state_t state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clear_last) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_LOOKUP;
			end
			ST_LOOKUP: begin
				if (sts.tlb_hit || sts.map_valid || sts.fresh_avail) begin
					if (sts.out_free) state_nxt = ST_IDLE;
				end else begin
					state_nxt = ST_OWNER;
				end
			end
			ST_OWNER: state_nxt = ST_CHECK;
			ST_CHECK: state_nxt = ST_FILL;
			ST_FILL: begin
				if (sts.out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_CLEAR;
		endcase
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_CLEAR: cmd.clear = 1'b1;
			ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
			end
			ST_LOOKUP: begin
				// priority: TLB, resident page, fresh frame, eviction
				if (sts.tlb_hit) begin
					cmd.hit_done = sts.out_free;
				end else if (sts.map_valid) begin
					cmd.map_done = sts.out_free;
				end else if (sts.fresh_avail) begin
					cmd.fresh_done = sts.out_free;
				end else begin
					cmd.evict_start = 1'b1;
				end
			end
			ST_OWNER: cmd.owner_rd    = 1'b1;
			ST_CHECK: cmd.evict_check = 1'b1;
			ST_FILL:  cmd.fill_done   = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

// File: sv/tlbpt_dp.sv
// ----------------------------------------------------------------------------
// tlbpt_dp
// Datapath: TLB registers, page map and frame owner memories, frame
// allocation counters and the result register.
// ----------------------------------------------------------------------------
module tlbpt_dp
	import tlbpt_pkg::*;
#(
	parameter int TLB_DEPTH   = TLB_DEPTH_DEF,
	parameter int PAGE_COUNT  = PAGE_COUNT_DEF,
	parameter int FRAME_COUNT = FRAME_COUNT_DEF,
	parameter int PAGE_BYTES  = PAGE_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tlbpt_cmd_t         cmd,
	output tlbpt_status_t      sts,
	input  logic               cfg_wr_en,
	input  logic [CFG_W-1:0]   cfg_wr_data,
	input  logic [ADDR_W-1:0]  logical_address,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [PADDR_W-1:0] physical_address,
	output logic               tlb_hit,
	output logic               page_loaded,
	output logic               evict_valid,
	output logic [EPAGE_W-1:0] evicted_page
);

	// Sizes are powers of two for page count and page bytes
	localparam int OB  = $clog2(PAGE_BYTES);
	localparam int PW  = $clog2(PAGE_COUNT);
	localparam int FW  = $clog2(FRAME_COUNT);
	localparam int CW  = $clog2(FRAME_COUNT + 1);
	localparam int TW  = $clog2(TLB_DEPTH);
	localparam int PFW = FW + OB;

	// Address split
	logic [ADDR_W-1:0] addr_shift;
	logic [PW-1:0]     in_page;
	logic [OB-1:0]     in_offset;

	assign addr_shift = logical_address >> OB;
	assign in_page    = addr_shift[PW-1:0];
	assign in_offset  = logical_address[OB-1:0];

	// Transaction registers
	logic [PW-1:0] page_q;
	logic [OB-1:0] offset_q;
	logic [FW-1:0] vframe_q;
	logic          ev_q;

	// Control registers
	logic [CFG_W-1:0] cfg_q;
	logic [CW-1:0]    alloc_q;
	logic [FW-1:0]    victim_q;
	logic [PW-1:0]    clr_q;
	logic [TW-1:0]    fill_q;
	logic             out_valid_q;

	// TLB
	logic          tlb_valid_q [TLB_DEPTH];
	logic [PW-1:0] tlb_page_q  [TLB_DEPTH];
	logic [FW-1:0] tlb_frame_q [TLB_DEPTH];

	// Memories: page map word is {valid, frame}
	logic [FW:0]   map_mem   [PAGE_COUNT];
	logic [FW:0]   map_rd_q;
	logic [PW-1:0] owner_mem [FRAME_COUNT];
	logic [PW-1:0] owner_rd_q;

	// Result register
	logic [PADDR_W-1:0] out_paddr_q;
	logic               out_hit_q;
	logic               out_fault_q;
	logic               out_ev_q;
	logic [EPAGE_W-1:0] out_epage_q;

	// Frame limit from the register, clamped to 1..FRAME_COUNT
	logic [CW-1:0] limit;
	always_comb begin
		if (cfg_q == '0) begin
			limit = CW'(1);
		end else if ({24'd0, cfg_q} > 32'(FRAME_COUNT)) begin
			limit = CW'(FRAME_COUNT);
		end else begin
			limit = CW'(cfg_q);
		end
	end

	// Round-robin victim with wrap when the limit was lowered
	logic [FW-1:0] vp;
	logic [FW-1:0] vp_next;
	always_comb begin
		vp = (CW'(victim_q) >= limit) ? '0 : victim_q;
		if (CW'(vp) + CW'(1) >= limit) begin
			vp_next = '0;
		end else begin
			vp_next = vp + FW'(1);
		end
	end

	// Parallel TLB compare, at most one entry matches
	logic [TLB_DEPTH-1:0] hit_vec;
	logic [TLB_DEPTH-1:0] drop_vec;
	logic [FW-1:0]        hit_frame;
	always_comb begin
		hit_frame = '0;
		for (int i = 0; i < TLB_DEPTH; i++) begin
			hit_vec[i]  = tlb_valid_q[i] && (tlb_page_q[i] == page_q);
			drop_vec[i] = tlb_valid_q[i] && (tlb_page_q[i] == owner_rd_q);
			if (hit_vec[i]) hit_frame = hit_frame | tlb_frame_q[i];
		end
	end

	logic evict_match;
	logic ins_en;
	logic emit;
	logic out_free;

	assign evict_match = map_rd_q[FW] && (map_rd_q[FW-1:0] == vframe_q);
	assign ins_en      = cmd.map_done || cmd.fresh_done || cmd.fill_done;
	assign emit        = cmd.hit_done || ins_en;
	assign out_free    = !out_valid_q || !out_stall;

	// Result frame
	logic [FW-1:0] res_frame;
	always_comb begin
		if (cmd.hit_done) begin
			res_frame = hit_frame;
		end else if (cmd.map_done) begin
			res_frame = map_rd_q[FW-1:0];
		end else if (cmd.fresh_done) begin
			res_frame = alloc_q[FW-1:0];
		end else begin
			res_frame = vframe_q;
		end
	end

	logic [PFW-1:0]         phys_full;
	logic [PFW+PADDR_W-1:0] phys_ext;
	logic [PW+EPAGE_W-1:0]  epage_ext;

	assign phys_full = {res_frame, offset_q};
	assign phys_ext  = (PFW + PADDR_W)'(phys_full);
	assign epage_ext = (PW + EPAGE_W)'(owner_rd_q);

	// Page map port muxing
	logic          map_we;
	logic [PW-1:0] map_waddr;
	logic [FW:0]   map_wdata;
	logic          map_re;
	logic [PW-1:0] map_raddr;
	always_comb begin
		map_we    = 1'b0;
		map_waddr = page_q;
		map_wdata = '0;
		if (cmd.clear) begin
			map_we    = 1'b1;
			map_waddr = clr_q;
		end else if (cmd.evict_check) begin
			map_we    = evict_match;
			map_waddr = owner_rd_q;
		end else if (cmd.fresh_done) begin
			map_we    = 1'b1;
			map_wdata = {1'b1, alloc_q[FW-1:0]};
		end else if (cmd.fill_done) begin
			map_we    = 1'b1;
			map_wdata = {1'b1, vframe_q};
		end
		map_re    = cmd.accept || cmd.owner_rd;
		map_raddr = cmd.accept ? in_page : owner_rd_q;
	end

	// Page map memory
	always_ff @(posedge clk) begin
		if (map_we) map_mem[map_waddr] <= map_wdata;
		if (map_re) map_rd_q <= map_mem[map_raddr];
	end

	// Frame owner memory
	logic          own_we;
	logic [FW-1:0] own_waddr;

	assign own_we    = cmd.fresh_done || cmd.fill_done;
	assign own_waddr = cmd.fresh_done ? alloc_q[FW-1:0] : vframe_q;

	always_ff @(posedge clk) begin
		if (own_we) owner_mem[own_waddr] <= page_q;
		if (cmd.evict_start) owner_rd_q <= owner_mem[vp];
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q       <= FRAMES_RESET;
			alloc_q     <= '0;
			victim_q    <= '0;
			clr_q       <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < TLB_DEPTH; i++) tlb_valid_q[i] <= 1'b0;
		end else begin
			if (cfg_wr_en) cfg_q <= cfg_wr_data;
			if (cmd.clear) clr_q <= clr_q + PW'(1);
			if (cmd.fresh_done) alloc_q <= alloc_q + CW'(1);
			if (cmd.evict_start) victim_q <= vp_next;
			// evicted page leaves the TLB
			if (cmd.evict_check && evict_match) begin
				for (int i = 0; i < TLB_DEPTH; i++) begin
					if (drop_vec[i]) tlb_valid_q[i] <= 1'b0;
				end
			end
			// FIFO refill
			if (ins_en) begin
				tlb_valid_q[fill_q] <= 1'b1;
				fill_q <= (fill_q == TW'(TLB_DEPTH - 1)) ? '0 : fill_q + TW'(1);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			page_q   <= in_page;
			offset_q <= in_offset;
			ev_q     <= 1'b0;
		end
		if (cmd.evict_start) vframe_q <= vp;
		if (cmd.evict_check) ev_q <= evict_match;
		if (ins_en) begin
			tlb_page_q[fill_q]  <= page_q;
			tlb_frame_q[fill_q] <= res_frame;
		end
		if (emit) begin
			out_paddr_q <= phys_ext[PADDR_W-1:0];
			out_hit_q   <= cmd.hit_done;
			out_fault_q <= cmd.fresh_done || cmd.fill_done;
			out_ev_q    <= cmd.fill_done && ev_q;
			out_epage_q <= (cmd.fill_done && ev_q) ? epage_ext[EPAGE_W-1:0] : '0;
		end
	end

	// Status
	assign sts.clear_last  = (clr_q == PW'(PAGE_COUNT - 1));
	assign sts.tlb_hit     = |hit_vec;
	assign sts.map_valid   = map_rd_q[FW];
	assign sts.fresh_avail = (alloc_q < limit);
	assign sts.out_free    = out_free;

	assign out_valid        = out_valid_q;
	assign physical_address = out_paddr_q;
	assign tlb_hit          = out_hit_q;
	assign page_loaded      = out_fault_q;
	assign evict_valid      = out_ev_q;
	assign evicted_page     = out_epage_q;

endmodule

// File: sv/tlbpt_checker.sv
// ----------------------------------------------------------------------------
// tlbpt_checker
// Port-level checks for the translator, bound to the top level.
// ----------------------------------------------------------------------------
module tlbpt_checker
	import tlbpt_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [PADDR_W-1:0] physical_address,
	input logic               tlb_hit,
	input logic               page_loaded,
	input logic               evict_valid,
	input logic [EPAGE_W-1:0] evicted_page
);

	// A stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(physical_address))
		else $error("stalled result changed");

	// One transaction in flight: stall rises right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second transaction taken while busy");

	// A TLB hit is never a fault
	a_hit_no_fault: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(tlb_hit && page_loaded))
		else $error("hit and fault together");

	// Eviction only on a fault
	a_evict_fault: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && evict_valid |-> page_loaded)
		else $error("eviction without fault");

	// Evicted page reads zero without eviction
	a_epage_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !evict_valid |-> evicted_page == '0)
		else $error("evicted page not zero");

endmodule

bind tlb_page_table_translator tlbpt_checker u_tlbpt_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_stall         (in_stall),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.physical_address (physical_address),
	.tlb_hit          (tlb_hit),
	.page_loaded      (page_loaded),
	.evict_valid      (evict_valid),
	.evicted_page     (evicted_page)
);

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for tlb_page_table_translator. A directed table walks
// the address extremes, TLB hits, refill wrap and page table hits after
// reset. Random traffic then runs under a series of frame limits, from one
// frame up to out-of-range values. Every transaction is predicted by a
// behavioral model of the TLB, page map and frame allocator kept inside the
// bench, and each result is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;
	import tlbpt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT   = 300000;
	localparam int PHASE_ITEMS   = 183;
	localparam int LONG_HOLD     = 80;
	localparam int DRAIN_CYCLES  = 16;
	localparam int TLB_SLOTS     = TLB_DEPTH_DEF;

	typedef enum int {
		MODE_RX_SLOW,
		MODE_TX_SLOW,
		MODE_NO_IDLE
	} idle_mode_t;

	typedef struct packed {
		logic [PADDR_W-1:0] pa;
		logic               hit;
		logic               fault;
		logic               ev;
		logic [EPAGE_W-1:0] ev_page;
	} xlate_t;

	typedef struct {
		logic [ADDR_W-1:0] addr;
		bit                typed;
		xlate_t            exp;
	} stim_row_t;

	// DUT ports
	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_wr_en = 1'b0;
	logic [CFG_W-1:0]   cfg_wr_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [ADDR_W-1:0]  logical_address = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [PADDR_W-1:0] physical_address;
	logic               tlb_hit;
	logic               page_loaded;
	logic               evict_valid;
	logic [EPAGE_W-1:0] evicted_page;

	// Value typed into the table for the transaction on offer
	bit     cur_typed = 1'b0;
	xlate_t cur_exp = '0;

	// Traffic shaping
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit long_hold_req = 1'b0;
	int hold_left = 0;

	// Bookkeeping
	xlate_t          pending_xlate[$];
	logic [7:0]      recent_pages[$];
	int              err_count = 0;
	int              cycles = 0;
	int              n_accepted = 0;
	int              n_hits = 0;
	int              n_faults = 0;
	int              n_evicts = 0;

	// Translator state as the bench sees it
	bit              res_valid [PAGE_COUNT_DEF];
	logic [6:0]      res_frame [PAGE_COUNT_DEF];
	logic [7:0]      owner_page [FRAME_COUNT_DEF];
	bit              tlb_ok [TLB_SLOTS];
	logic [7:0]      tlb_vpage [TLB_SLOTS];
	logic [6:0]      tlb_pframe [TLB_SLOTS];
	logic [3:0]      tlb_fill = '0;
	logic [7:0]      frames_handed = '0;
	logic [6:0]      victim_frame = '0;
	logic [CFG_W-1:0] frames_cfg = FRAMES_RESET;

	tlb_page_table_translator DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.logical_address  (logical_address),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.physical_address (physical_address),
		.tlb_hit          (tlb_hit),
		.page_loaded      (page_loaded),
		.evict_valid      (evict_valid),
		.evicted_page     (evicted_page)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Run watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("%0t ns: timeout with %0d transactions outstanding", $time,
				pending_xlate.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// FIFO refill of one TLB slot
	function automatic void tlb_refill(input logic [7:0] pg, input logic [6:0] fr);
		tlb_ok[tlb_fill] = 1'b1;
		tlb_vpage[tlb_fill] = pg;
		tlb_pframe[tlb_fill] = fr;
		tlb_fill = tlb_fill + 4'd1;
	endfunction

	// Predict one translation and advance the bench's copy of the state
	function automatic xlate_t translate(input logic [ADDR_W-1:0] la);
		logic [7:0] pg;
		logic [7:0] off;
		logic [7:0] lim;
		logic [7:0] old;
		logic [6:0] fr;
		bit         found;
		xlate_t     r;
		pg = la[15:8];
		off = la[7:0];
		r = '0;
		fr = '0;
		found = 1'b0;
		for (int i = 0; i < TLB_SLOTS; i++) begin
			if (!found && tlb_ok[i] && tlb_vpage[i] == pg) begin
				fr = tlb_pframe[i];
				found = 1'b1;
			end
		end
		if (found) begin
			r.hit = 1'b1;
		end else if (res_valid[pg]) begin
			fr = res_frame[pg];
			tlb_refill(pg, fr);
		end else begin
			// zero acts as one frame, anything above the frame count is clamped
			if (frames_cfg == 0)
				lim = 8'd1;
			else if (frames_cfg > FRAME_COUNT_DEF)
				lim = 8'(FRAME_COUNT_DEF);
			else
				lim = frames_cfg;
			r.fault = 1'b1;
			if (frames_handed < lim) begin
				fr = frames_handed[6:0];
				frames_handed = frames_handed + 8'd1;
			end else begin
				// round-robin victim, wrapped when the limit dropped below it
				if ({1'b0, victim_frame} >= lim)
					victim_frame = '0;
				fr = victim_frame;
				victim_frame = ({1'b0, victim_frame} + 8'd1 >= lim) ? 7'd0 :
					victim_frame + 7'd1;
				old = owner_page[fr];
				if (res_valid[old] && res_frame[old] == fr) begin
					res_valid[old] = 1'b0;
					for (int i = 0; i < TLB_SLOTS; i++)
						if (tlb_ok[i] && tlb_vpage[i] == old)
							tlb_ok[i] = 1'b0;
					r.ev = 1'b1;
					r.ev_page = old;
				end
			end
			owner_page[fr] = pg;
			res_valid[pg] = 1'b1;
			res_frame[pg] = fr;
			tlb_refill(pg, fr);
		end
		r.pa = {fr, off};
		return r;
	endfunction

	task automatic check_field(input string fname, input int unsigned want,
			input int unsigned seen);
		if (want != seen) begin
			$display("%0t ns: %s mismatch, expected %0h actual %0h", $time, fname,
				want, seen);
			err_count++;
		end
	endtask

	// Accepted transactions, register writes and result checking
	always @(posedge clk) begin
		xlate_t pred;
		xlate_t want;
		if (arst_n) begin
			if (cfg_wr_en)
				frames_cfg = cfg_wr_data;
			if (in_valid && !in_stall) begin
				pred = translate(logical_address);
				pending_xlate.push_back(cur_typed ? cur_exp : pred);
				n_accepted++;
			end
			if (out_valid && !out_stall) begin
				if (pending_xlate.size() == 0) begin
					$display("%0t ns: result with no transaction pending, pa %0h", $time,
						physical_address);
					err_count++;
				end else begin
					want = pending_xlate.pop_front();
					check_field("physical_address", want.pa, physical_address);
					check_field("tlb_hit", want.hit, tlb_hit);
					check_field("page_loaded", want.fault, page_loaded);
					check_field("evict_valid", want.ev, evict_valid);
					check_field("evicted_page", want.ev_page, evicted_page);
					n_hits += tlb_hit;
					n_faults += page_loaded;
					n_evicts += evict_valid;
				end
			end
		end
	end

	// Receiver: random stalls plus an occasional long hold-off
	initial begin
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				hold_left = LONG_HOLD;
				long_hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				out_stall = 1'b1;
				hold_left--;
			end else begin
				out_stall = ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	task automatic apply_idle_mode(input idle_mode_t mode);
		case (mode)
			MODE_RX_SLOW: begin
				send_idle_pct = 27;
				recv_idle_pct = 47;
			end
			MODE_TX_SLOW: begin
				send_idle_pct = 47;
				recv_idle_pct = 27;
			end
			default: begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
		endcase
	endtask

	// Offer one transaction; called and returns at a falling edge
	task automatic offer(input logic [ADDR_W-1:0] a, input bit typed, input xlate_t ex);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		logical_address = a;
		cur_typed = typed;
		cur_exp = ex;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// Wait at a falling edge until every result is back
	task automatic drain();
		in_valid = 1'b0;
		while (pending_xlate.size() != 0)
			@(negedge clk);
	endtask

	function automatic stim_row_t dir_row(input logic [ADDR_W-1:0] a, input bit typed,
			input logic [PADDR_W-1:0] pa, input logic h, input logic f);
		dir_row.addr = a;
		dir_row.typed = typed;
		dir_row.exp = '0;
		dir_row.exp.pa = pa;
		dir_row.exp.hit = h;
		dir_row.exp.fault = f;
	endfunction

	// Mix of recently used pages, a small working set and scattered pages
	function automatic logic [ADDR_W-1:0] next_address(input logic [7:0] ws_base);
		logic [7:0] pg;
		int         pick;
		pick = $urandom_range(99);
		if (pick < 40 && recent_pages.size() != 0)
			pg = recent_pages[$urandom_range(recent_pages.size() - 1)];
		else if (pick < 70)
			pg = ws_base + 8'($urandom_range(23));
		else
			pg = 8'($urandom);
		recent_pages.push_back(pg);
		if (recent_pages.size() > 8)
			void'(recent_pages.pop_front());
		return {pg, 8'($urandom)};
	endfunction

	// Main sequence
	initial begin
		stim_row_t  rows[$];
		logic [7:0] limits[9];
		logic [7:0] ws_base;
		xlate_t     none;

		none = '0;
		limits = '{8'd1, 8'd128, 8'd0, 8'd255, 8'd3, 8'd129, 8'd64, 8'd2, 8'd0};
		limits[8] = 8'($urandom_range(1, 255));

		// Fresh state at the default limit of 128 frames
		rows.push_back(dir_row(16'h0000, 1'b1, 15'h0000, 1'b0, 1'b1));
		rows.push_back(dir_row(16'h00FF, 1'b1, 15'h00FF, 1'b1, 1'b0));
		rows.push_back(dir_row(16'hFFFF, 1'b1, 15'h01FF, 1'b0, 1'b1));
		rows.push_back(dir_row(16'hFF00, 1'b1, 15'h0100, 1'b1, 1'b0));
		rows.push_back(dir_row(16'h8001, 1'b1, 15'h0201, 1'b0, 1'b1));
		rows.push_back(dir_row(16'h7FFE, 1'b1, 15'h03FE, 1'b0, 1'b1));
		rows.push_back(dir_row(16'hAAAA, 1'b1, 15'h04AA, 1'b0, 1'b1));
		rows.push_back(dir_row(16'h5555, 1'b1, 15'h0555, 1'b0, 1'b1));
		// Eleven more fresh pages wrap the TLB refill over page zero
		rows.push_back(dir_row(16'h0110, 1'b0, '0, 1'b0, 1'b0));
		rows.push_back(dir_row(16'h0220, 1'b0, '0, 1'b0, 1'b0));
		rows.push_back(dir_row(16'h0330, 1'b0, '0, 1'b0, 1'b0));
		rows.push_back(dir_row(16'h0440, 1'b0, '0, 1'b0, 1'b0));
		rows.push_back(dir_row(16'h0550, 1'b0, '0, 1'b0, 1'b0));
		rows.push_back(dir_row(16'h0660, 1'b0, '0, 1'b0, 1'b0));
		rows.push_back(dir_row(16'h0770, 1'b0, '0, 1'b0, 1'b0));
		rows.push_back(dir_row(16'h0880, 1'b0, '0, 1'b0, 1'b0));
		rows.push_back(dir_row(16'h0990, 1'b0, '0, 1'b0, 1'b0));
		rows.push_back(dir_row(16'h0AA0, 1'b0, '0, 1'b0, 1'b0));
		rows.push_back(dir_row(16'h0BB0, 1'b0, '0, 1'b0, 1'b0));
		// Page zero now resolves through the page map only
		rows.push_back(dir_row(16'h0042, 1'b1, 15'h0042, 1'b0, 1'b0));
		rows.push_back(dir_row(16'hFF10, 1'b0, '0, 1'b0, 1'b0));
		rows.push_back(dir_row(16'h0BFF, 1'b0, '0, 1'b0, 1'b0));

		apply_idle_mode(MODE_RX_SLOW);

		// Hold reset, then release it; the clearing pass is absorbed by in_stall
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table
		foreach (rows[i])
			offer(rows[i].addr, rows[i].typed, rows[i].exp);
		drain();

		// Random phases, each under its own frame limit
		foreach (limits[p]) begin
			apply_idle_mode(idle_mode_t'(p / 3));
			cfg_wr_en = 1'b1;
			cfg_wr_data = limits[p];
			@(negedge clk);
			cfg_wr_en = 1'b0;
			ws_base = 8'($urandom);
			if (p == 4)
				long_hold_req = 1'b1;
			for (int k = 0; k < PHASE_ITEMS; k++)
				offer(next_address(ws_base), 1'b0, none);
			drain();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Translated %0d addresses over %0d frame limit settings (1 to 255, and 0)",
			n_accepted, $size(limits));
		$display("Seen: %0d TLB hits, %0d page faults, %0d evictions",
			n_hits, n_faults, n_evicts);
		if (err_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
